FILE: sv/asipm_pkg.sv
// Package for the Annex B insertion-point marker: transfer types, register
// indexes, delay-line sizes and the NAL header slice test. No dependencies.
package asipm_pkg;

    // One input transfer: a stream byte and its end-of-access-unit flag.
    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_in;
    } t_in_item;

    // One result transfer: the delayed byte and its marks.
    typedef struct packed {
        logic [7:0] byte_out;
        logic       last_out;
        logic       insert_before;
        logic       insert_after;
    } t_out_item;

    // Configuration register indexes (byte address is four times the index).
    typedef enum logic {
        REG_CODEC_IS_H265 = 1'b0,
        REG_MARK_ENABLE   = 1'b1
    } t_reg_index;

    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;

    // Bytes held back so a start code is still present when its header arrives.
    localparam int unsigned HOLD_DEPTH = 4;
    // One more slot holds a byte that has left the delay line but not yet
    // moved into the output register.
    localparam int unsigned BUF_DEPTH  = HOLD_DEPTH + 1;
    localparam int unsigned CNT_W      = $clog2(BUF_DEPTH + 1);
    localparam int unsigned IDX_W      = $clog2(BUF_DEPTH);

    localparam logic [7:0] H264_TYPE_MASK = 8'h1F;
    localparam logic [7:0] H265_TYPE_MASK = 8'h3F;
    localparam logic [7:0] H264_SLICE_LO  = 8'd1;
    localparam logic [7:0] H264_SLICE_HI  = 8'd5;
    localparam logic [7:0] H265_SLICE_HI  = 8'd9;

    // True when the NAL header type is 1 to 5 (H.264) or 0 to 9 (H.265).
    function automatic logic header_is_slice(input logic [7:0] hdr, input logic is_h265);
        logic [7:0] nal_type;
        logic       result;
        if (is_h265) begin
            nal_type = (hdr >> 1) & H265_TYPE_MASK;
            result   = (nal_type <= H265_SLICE_HI);
        end else begin
            nal_type = hdr & H264_TYPE_MASK;
            result   = (nal_type >= H264_SLICE_LO) && (nal_type <= H264_SLICE_HI);
        end
        return result;
    endfunction

endpackage

FILE: sv/annexb_sei_insert_point_marker.sv
// Annex B insertion-point marker: start code scanner, byte delay line,
// result register and APB register file. Depends on asipm_pkg.
//
// Channel   Direction  Handshake              Payload
// input     in         i_valid / o_stall      i_data  (byte_in, last_in)
// output    out        o_valid / i_stall      o_data  (byte_out, last_out, marks)
// config    in         psel/penable/pready    paddr, pwdata, prdata
//
// One byte is accepted per cycle while the output is not stalled and no drain
// runs; with bytes arriving back to back, each byte passes through the delay
// line and its spare slot before it reaches the output register.
// After a byte with last_in, the held bytes drain one per cycle while the
// output is not stalled, and no input is taken until the drain ends.
// Reset is synchronous and active low; it clears the scan state, the delay
// line count and the output valid, and sets the registers to their defaults.
// A stall on the output holds the result register; input then stalls only
// once the delay line and its spare slot are full, or while a drain runs.
module annexb_sei_insert_point_marker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input stream
    input  logic                                i_valid,
    output logic                                o_stall,
    input  asipm_pkg::t_in_item                 i_data,
    // Output stream
    output logic                                o_valid,
    input  logic                                i_stall,
    output asipm_pkg::t_out_item                o_data,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [asipm_pkg::PADDR_W-1:0]       paddr,
    input  logic [asipm_pkg::PDATA_W-1:0]       pwdata,
    output logic [asipm_pkg::PDATA_W-1:0]       prdata,
    output logic                                pready
);
    import asipm_pkg::*;

    // Configuration registers.
    logic r_codec_is_h265;
    logic r_mark_enable;

    // Scan state.
    logic [1:0] r_zero_run,  n_zero_run;
    logic       r_expect_hdr, n_expect_hdr;
    logic       r_long_sc,   n_long_sc;
    logic       r_found,     n_found;

    // Delay line with one spare slot, oldest entry at index 0.
    logic [7:0]       r_bytes [BUF_DEPTH];
    logic [7:0]       n_bytes [BUF_DEPTH];
    logic             r_marks [BUF_DEPTH];
    logic             n_marks [BUF_DEPTH];
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_drain, n_drain;
    logic             r_after, n_after;

    // Result register.
    logic      r_out_valid;
    t_out_item r_out;

    logic             cfg_write;
    t_reg_index       reg_sel;
    logic             out_free;
    logic             pop;
    logic             accept;
    logic [CNT_W-1:0] held;
    logic [CNT_W-1:0] sc_len;
    logic [CNT_W-1:0] mark_pos;
    logic [CNT_W-1:0] wr_pos;
    logic             slice_hit;
    logic             mark_hit;

    // Register file: writes complete on the access cycle, reads are direct.
    assign pready    = 1'b1;
    assign reg_sel   = t_reg_index'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codec_is_h265 <= 1'b0;
            r_mark_enable   <= 1'b1;
        end else if (cfg_write) begin
            case (reg_sel)
                REG_CODEC_IS_H265: r_codec_is_h265 <= pwdata[0];
                REG_MARK_ENABLE:   r_mark_enable   <= pwdata[0];
                default:           r_mark_enable   <= r_mark_enable;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_CODEC_IS_H265: prdata = {{(PDATA_W-1){1'b0}}, r_codec_is_h265};
            REG_MARK_ENABLE:   prdata = {{(PDATA_W-1){1'b0}}, r_mark_enable};
            default:           prdata = '0;
        endcase
    end

    // Handshake: pop the oldest entry when the line is full or drains.
    assign out_free = !r_out_valid || !i_stall;
    assign pop      = out_free &&
                      ((r_count == CNT_W'(BUF_DEPTH)) || (r_drain && (r_count != '0)));
    assign o_stall  = r_drain || ((r_count == CNT_W'(BUF_DEPTH)) && !pop);
    assign accept   = i_valid && !o_stall;

    // Bytes still held in the delay line proper, and where a start code began.
    assign held      = (r_count == CNT_W'(BUF_DEPTH)) ? CNT_W'(HOLD_DEPTH) : r_count;
    assign sc_len    = r_long_sc ? CNT_W'(4) : CNT_W'(3);
    assign mark_pos  = r_count - sc_len;
    assign slice_hit = r_expect_hdr && !r_found &&
                       header_is_slice(i_data.byte_in, r_codec_is_h265);
    assign mark_hit  = accept && slice_hit && r_mark_enable && (held >= sc_len);
    assign wr_pos    = r_count - CNT_W'(pop);

    // Start code scan on each accepted byte.
    always_comb begin
        n_zero_run   = r_zero_run;
        n_expect_hdr = r_expect_hdr;
        n_long_sc    = r_long_sc;
        n_found      = r_found;
        n_after      = r_after;
        if (accept) begin
            if (r_expect_hdr) begin
                n_expect_hdr = 1'b0;
                n_long_sc    = 1'b0;
                n_zero_run   = 2'd0;
                if (slice_hit) begin
                    n_found = 1'b1;
                end
            end else if (i_data.byte_in == 8'd0) begin
                if (r_zero_run != 2'd3) begin
                    n_zero_run = r_zero_run + 2'd1;
                end
            end else begin
                if ((i_data.byte_in == 8'd1) && (r_zero_run >= 2'd2)) begin
                    n_expect_hdr = 1'b1;
                    n_long_sc    = (r_zero_run == 2'd3);
                end
                n_zero_run = 2'd0;
            end
            // End of access unit: note the fallback mark, restart the scan.
            if (i_data.last_in) begin
                n_after      = r_mark_enable && !n_found;
                n_zero_run   = 2'd0;
                n_expect_hdr = 1'b0;
                n_long_sc    = 1'b0;
                n_found      = 1'b0;
            end
        end
    end

    // Delay line: mark, shift out the oldest, then append the new byte.
    always_comb begin
        for (int i = 0; i < BUF_DEPTH; i++) begin
            n_bytes[i] = r_bytes[i];
            n_marks[i] = r_marks[i];
        end
        if (mark_hit) begin
            n_marks[mark_pos[IDX_W-1:0]] = 1'b1;
        end
        if (pop) begin
            for (int i = 0; i < BUF_DEPTH - 1; i++) begin
                n_bytes[i] = n_bytes[i+1];
                n_marks[i] = n_marks[i+1];
            end
        end
        if (accept) begin
            n_bytes[wr_pos[IDX_W-1:0]] = i_data.byte_in;
            n_marks[wr_pos[IDX_W-1:0]] = 1'b0;
        end
        n_count = r_count - CNT_W'(pop) + CNT_W'(accept);
        n_drain = r_drain;
        if (accept && i_data.last_in) begin
            n_drain = 1'b1;
        end else if (pop && r_drain && (r_count == CNT_W'(1))) begin
            n_drain = 1'b0;
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_run   <= 2'd0;
            r_expect_hdr <= 1'b0;
            r_long_sc    <= 1'b0;
            r_found      <= 1'b0;
            r_after      <= 1'b0;
            r_count      <= '0;
            r_drain      <= 1'b0;
        end else begin
            r_zero_run   <= n_zero_run;
            r_expect_hdr <= n_expect_hdr;
            r_long_sc    <= n_long_sc;
            r_found      <= n_found;
            r_after      <= n_after;
            r_count      <= n_count;
            r_drain      <= n_drain;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < BUF_DEPTH; i++) begin
            r_bytes[i] <= n_bytes[i];
            r_marks[i] <= n_marks[i];
        end
    end

    // Result register: loads the popped entry; the last drained one ends the unit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out.byte_out      <= r_bytes[0];
            r_out.insert_before <= r_marks[0];
            r_out.last_out      <= r_drain && (r_count == CNT_W'(1));
            r_out.insert_after  <= r_drain && (r_count == CNT_W'(1)) && r_after;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // The fallback mark only ever sits on the final byte of a unit.
    a_after_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.insert_after |-> o_data.last_out)
        else $error("insert_after on a byte that does not end the unit");

    // A byte never carries both marks.
    a_marks_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_data.insert_before && o_data.insert_after))
        else $error("both insertion marks on one byte");

    // The delay line never overfills.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(BUF_DEPTH))
        else $error("delay line count out of range");

    // A drain always has bytes left to send.
    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain |-> (r_count != '0))
        else $error("drain active with an empty delay line");

    // The end of a unit starts a drain on the next cycle.
    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_data.last_in |=> r_drain)
        else $error("last byte accepted without starting a drain");

endmodule
